[rtl/core/mdc_pkg.sv]
// Shared types, constants and helper functions for the depth-first maze carver.
// No dependencies; compile first.
`timescale 1ns / 1ps
`default_nettype none

package mdc_pkg;

	// Largest supported side length of the maze, in cells
	localparam int GRID_SIDE_DEF = 32;

	// Side length register reset value
	localparam logic [5:0] GRID_SIZE_RST = 6'd25;

	// Wall mask bits: N E S W
	localparam logic [3:0] MASK_ALL    = 4'b1111;
	localparam logic [3:0] KEEP_NOT_N  = 4'b0111;
	localparam logic [3:0] KEEP_NOT_E  = 4'b1011;
	localparam logic [3:0] KEEP_NOT_S  = 4'b1101;
	localparam logic [3:0] KEEP_NOT_W  = 4'b1110;

	// Neighbor directions, in candidate order
	typedef enum logic [1:0] {
		DIR_W = 2'd0,
		DIR_E = 2'd1,
		DIR_N = 2'd2,
		DIR_S = 2'd3
	} dir_t;

	typedef struct packed {
		logic [15:0] random_a;
		logic [15:0] random_b;
	} req_t;

	typedef struct packed {
		logic [4:0] cur_x;
		logic [4:0] cur_y;
		logic [3:0] cur_mask;
		logic [4:0] next_x;
		logic [4:0] next_y;
		logic [3:0] next_mask;
		logic       carved;
		logic       started;
		logic       done_res;
	} rsp_t;

	// Mask applied to the current cell when a passage opens toward dir
	function automatic logic [3:0] keep_cur(input dir_t dir);
		logic [3:0] m;
		case (dir)
			DIR_W:   m = KEEP_NOT_W;
			DIR_E:   m = KEEP_NOT_E;
			DIR_N:   m = KEEP_NOT_N;
			DIR_S:   m = KEEP_NOT_S;
			default: m = MASK_ALL;
		endcase
		return m;
	endfunction

	// Mask applied to the neighbor: the opposite wall
	function automatic logic [3:0] keep_nb(input dir_t dir);
		logic [3:0] m;
		case (dir)
			DIR_W:   m = KEEP_NOT_E;
			DIR_E:   m = KEEP_NOT_W;
			DIR_N:   m = KEEP_NOT_S;
			DIR_S:   m = KEEP_NOT_N;
			default: m = MASK_ALL;
		endcase
		return m;
	endfunction

	// v mod 3: base-4 digits sum to the same residue, then fold once and subtract 3 or 6
	function automatic logic [1:0] mod3_u16(input logic [15:0] v);
		logic [4:0] s;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < 8; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		if (t >= 3'd6) begin
			t = t - 3'd6;
		end else if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/core/mdc_stream_if.sv]
// Valid/ready channel with a typed payload, used for all ports of the carver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mdc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/maze_dfs_carver.sv]
// Randomized depth-first maze carver. Uses mdc_pkg, mdc_stream_if and mdc_ram.
// Carve item: pop the stack, read the current cell and its four neighbors, select a
// neighbor, write back, then output; a dead end skips the neighbor write. The single
// read port of the cell-state memory sets the pace (current cell plus four neighbors).
// Start item: remainder pass, clearing pass over the cell-state memory, then the result.
// Reset clears control state only; each start item clears the cell-state memory.
`timescale 1ns / 1ps
`default_nettype none

module maze_dfs_carver #(
	parameter int GRID_SIDE = mdc_pkg::GRID_SIDE_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	mdc_stream_if.sink   req,
	mdc_stream_if.source rsp,
	mdc_stream_if.sink   cfg
);

	import mdc_pkg::*;

	localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
	localparam int AW         = $clog2(CELL_COUNT);   // cell address
	localparam int CW         = $clog2(GRID_SIDE);    // one coordinate
	localparam int SW         = $clog2(GRID_SIDE + 1); // side length
	localparam int CELL_W     = 5;                    // {visited, mask}
	localparam int STK_W      = 2 * CW;               // {y, x}

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_MOD    = 13'b0000000000010,
		S_CLEAR  = 13'b0000000000100,
		S_RD_STK = 13'b0000000001000,
		S_RD_CUR = 13'b0000000010000,
		S_RD_W   = 13'b0000000100000,
		S_RD_E   = 13'b0000001000000,
		S_RD_N   = 13'b0000010000000,
		S_RD_S   = 13'b0000100000000,
		S_SEL    = 13'b0001000000000,
		S_WR_CUR = 13'b0010000000000,
		S_WR_NB  = 13'b0100000000000,
		S_OUT    = 13'b1000000000000
	} state_t;

	// Row-major cell address
	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
	                                             input logic [CW-1:0] y);
		return AW'(int'(y) * GRID_SIDE + int'(x));
	endfunction

	// One step of a restoring remainder: shift in a bit, subtract if it fits
	function automatic logic [SW-1:0] rem_step(input logic [SW-1:0] r,
	                                           input logic          b,
	                                           input logic [SW-1:0] d);
		logic [SW:0] t;
		t = {r, b};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[SW-1:0];
	endfunction

	// Control state
	state_t         state_q;
	logic           running_q;
	logic [AW:0]    count_q;       // stack fill
	logic           rsp_valid_q;
	logic [5:0]     grid_size_q;
	logic [SW-1:0]  side_q;        // side latched at maze start
	logic [3:0]     mod_cnt_q;
	logic [AW-1:0]  clr_q;

	// Item payload
	logic [15:0]    ra_q;
	logic [15:0]    rb_q;
	logic [1:0]     ra_mod3_q;
	logic [1:0]     ra_lo_q;
	logic [SW-1:0]  rem_a_q;
	logic [SW-1:0]  rem_b_q;
	logic           start_q;
	logic [CW-1:0]  cx_q;
	logic [CW-1:0]  cy_q;
	logic [CW-1:0]  nx_q;
	logic [CW-1:0]  ny_q;
	logic [3:0]     cur_mask_q;
	logic [3:0]     nb_mask_q;
	logic           carved_q;
	logic [2:0]     vis_q;
	logic [3:0]     nbm_q [3];
	rsp_t           rsp_q;

	// Memory ports
	logic              cell_we;
	logic [AW-1:0]     cell_waddr;
	logic [CELL_W-1:0] cell_wdata;
	logic [AW-1:0]     cell_raddr;
	logic [CELL_W-1:0] cell_rdata;
	logic              stk_we;
	logic [AW-1:0]     stk_waddr;
	logic [STK_W-1:0]  stk_wdata;
	logic [AW-1:0]     stk_raddr;
	logic [STK_W-1:0]  stk_rdata;

	logic              accept;
	logic              start_path;
	logic              out_free;
	logic [AW:0]       cnt_dec;
	logic              stk_room;
	logic [SW-1:0]     side_clamp;
	logic [SW-1:0]     rem_a_nxt;
	logic [SW-1:0]     rem_b_nxt;
	logic [CW-1:0]     stk_x;
	logic [CW-1:0]     stk_y;

	// Neighbor choice
	logic [3:0]        cand;
	logic [2:0]        n_cand;
	logic [1:0]        pick_k;
	logic [2:0]        seen;
	logic              found;
	dir_t              pick_dir;
	logic [3:0]        pick_mask;
	logic              east_ok;
	logic              south_ok;
	rsp_t              rsp_nxt;

	mdc_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cell_ram (
		.clk   (clk),
		.we    (cell_we),
		.waddr (cell_waddr),
		.wdata (cell_wdata),
		.raddr (cell_raddr),
		.rdata (cell_rdata)
	);

	mdc_ram #(
		.WIDTH (STK_W),
		.DEPTH (CELL_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Handshakes: config always taken; one item in flight at a time, the
	// output register lets the next item enter while a result waits.
	assign cfg.ready  = 1'b1;
	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_q;
	assign accept     = req.valid && (state_q == S_IDLE);
	assign start_path = !running_q || (count_q == '0);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign cnt_dec    = count_q - (AW + 1)'(1);
	assign stk_room   = (count_q != (AW + 1)'(CELL_COUNT));
	assign stk_x      = stk_rdata[CW-1:0];
	assign stk_y      = stk_rdata[STK_W-1:CW];

	// Clamp the side register to 1..GRID_SIDE
	always_comb begin
		if (grid_size_q == '0) begin
			side_clamp = SW'(1);
		end else if (int'(grid_size_q) > GRID_SIDE) begin
			side_clamp = SW'(GRID_SIDE);
		end else begin
			side_clamp = SW'(grid_size_q);
		end
	end

	// Start coordinates: feed the random words MSB first through the remainder step
	assign rem_a_nxt = rem_step(rem_a_q, ra_q[15], side_q);
	assign rem_b_nxt = rem_step(rem_b_q, rb_q[15], side_q);

	// Candidate neighbors in order W, E, N, S; south's visited bit arrives from memory
	assign east_ok  = ({1'b0, SW'(cx_q)} + (SW + 1)'(1)) < {1'b0, side_q};
	assign south_ok = ({1'b0, SW'(cy_q)} + (SW + 1)'(1)) < {1'b0, side_q};

	always_comb begin
		cand[0] = (cx_q != '0) && !vis_q[0];
		cand[1] = east_ok && !vis_q[1];
		cand[2] = (cy_q != '0) && !vis_q[2];
		cand[3] = south_ok && !cell_rdata[4];
		n_cand  = 3'($countones(cand));
		case (n_cand)
			3'd2:    pick_k = {1'b0, ra_lo_q[0]};
			3'd3:    pick_k = ra_mod3_q;
			3'd4:    pick_k = ra_lo_q;
			default: pick_k = 2'd0;
		endcase
		// Take the pick_k-th set candidate
		pick_dir = DIR_W;
		found    = 1'b0;
		seen     = '0;
		for (int d = 0; d < 4; d++) begin
			if (cand[d]) begin
				if (!found && (seen == {1'b0, pick_k})) begin
					pick_dir = dir_t'(2'(d));
					found    = 1'b1;
				end
				seen = seen + 3'd1;
			end
		end
		case (pick_dir)
			DIR_W:   pick_mask = nbm_q[0];
			DIR_E:   pick_mask = nbm_q[1];
			DIR_N:   pick_mask = nbm_q[2];
			DIR_S:   pick_mask = cell_rdata[3:0];
			default: pick_mask = MASK_ALL;
		endcase
	end

	// Memory access per state: one cell read a cycle, writes after all reads
	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = clr_q;
		cell_wdata = {1'b0, MASK_ALL};
		cell_raddr = cell_addr(cx_q, cy_q);
		stk_we     = 1'b0;
		stk_waddr  = count_q[AW-1:0];
		stk_wdata  = {cy_q, cx_q};
		stk_raddr  = cnt_dec[AW-1:0];
		case (state_q)
			S_CLEAR: begin
				cell_we = 1'b1;
				// push the start cell at the bottom of the stack
				stk_we    = (clr_q == '0);
				stk_waddr = '0;
			end
			S_RD_CUR: begin
				cell_raddr = cell_addr(stk_x, stk_y);
			end
			S_RD_W: begin
				cell_raddr = cell_addr(cx_q - CW'(1), cy_q);
			end
			S_RD_E: begin
				cell_raddr = cell_addr(cx_q + CW'(1), cy_q);
			end
			S_RD_N: begin
				cell_raddr = cell_addr(cx_q, cy_q - CW'(1));
			end
			S_RD_S: begin
				cell_raddr = cell_addr(cx_q, cy_q + CW'(1));
			end
			S_WR_CUR: begin
				cell_we    = 1'b1;
				cell_waddr = cell_addr(cx_q, cy_q);
				cell_wdata = {1'b1, cur_mask_q};
				stk_we     = carved_q && stk_room;
			end
			S_WR_NB: begin
				cell_we    = 1'b1;
				cell_waddr = cell_addr(nx_q, ny_q);
				cell_wdata = {1'b0, nb_mask_q};
				stk_we     = stk_room;
				stk_wdata  = {ny_q, nx_q};
			end
			default: begin
			end
		endcase
	end

	// Result of the finished item
	always_comb begin
		rsp_nxt           = '0;
		rsp_nxt.cur_x     = 5'(cx_q);
		rsp_nxt.cur_y     = 5'(cy_q);
		rsp_nxt.cur_mask  = cur_mask_q;
		rsp_nxt.carved    = carved_q;
		rsp_nxt.started   = start_q;
		rsp_nxt.done_res  = !start_q && (count_q == '0);
		if (carved_q) begin
			rsp_nxt.next_x    = 5'(nx_q);
			rsp_nxt.next_y    = 5'(ny_q);
			rsp_nxt.next_mask = nb_mask_q;
		end
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			grid_size_q <= GRID_SIZE_RST;
			side_q      <= SW'(1);
			mod_cnt_q   <= '0;
			clr_q       <= '0;
		end else begin
			if (cfg.valid) begin
				grid_size_q <= cfg.data;
			end
			// load the output register when a result leaves S_OUT, else drop it once taken
			if ((state_q == S_OUT) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (start_path) begin
							side_q    <= side_clamp;
							count_q   <= '0;
							mod_cnt_q <= '0;
							state_q   <= S_MOD;
						end else begin
							state_q <= S_RD_STK;
						end
					end
				end
				S_MOD: begin
					mod_cnt_q <= mod_cnt_q + 4'd1;
					if (mod_cnt_q == 4'd15) begin
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CELL_COUNT - 1)) begin
						count_q   <= (AW + 1)'(1);
						running_q <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_RD_STK: begin
					// pop
					count_q <= cnt_dec;
					state_q <= S_RD_CUR;
				end
				S_RD_CUR: state_q <= S_RD_W;
				S_RD_W:   state_q <= S_RD_E;
				S_RD_E:   state_q <= S_RD_N;
				S_RD_N:   state_q <= S_RD_S;
				S_RD_S:   state_q <= S_SEL;
				S_SEL:    state_q <= S_WR_CUR;
				S_WR_CUR: begin
					if (carved_q) begin
						if (stk_room) begin
							count_q <= count_q + (AW + 1)'(1);
						end
						state_q <= S_WR_NB;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_WR_NB: begin
					if (stk_room) begin
						count_q <= count_q + (AW + 1)'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the output register is free
					if (out_free) begin
						if (rsp_nxt.done_res) begin
							running_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ra_q       <= req.data.random_a;
					rb_q       <= req.data.random_b;
					ra_mod3_q  <= mod3_u16(req.data.random_a);
					ra_lo_q    <= req.data.random_a[1:0];
					rem_a_q    <= '0;
					rem_b_q    <= '0;
					start_q    <= start_path;
					carved_q   <= 1'b0;
					cur_mask_q <= MASK_ALL;
				end
			end
			S_MOD: begin
				rem_a_q <= rem_a_nxt;
				rem_b_q <= rem_b_nxt;
				ra_q    <= {ra_q[14:0], 1'b0};
				rb_q    <= {rb_q[14:0], 1'b0};
				// remainders are below side, so they fit a coordinate
				cx_q    <= CW'(rem_a_nxt);
				cy_q    <= CW'(rem_b_nxt);
			end
			S_RD_CUR: begin
				cx_q <= stk_x;
				cy_q <= stk_y;
			end
			S_RD_W: begin
				cur_mask_q <= cell_rdata[3:0];
			end
			S_RD_E: begin
				vis_q[0] <= cell_rdata[4];
				nbm_q[0] <= cell_rdata[3:0];
			end
			S_RD_N: begin
				vis_q[1] <= cell_rdata[4];
				nbm_q[1] <= cell_rdata[3:0];
			end
			S_RD_S: begin
				vis_q[2] <= cell_rdata[4];
				nbm_q[2] <= cell_rdata[3:0];
			end
			S_SEL: begin
				carved_q  <= |cand;
				nb_mask_q <= pick_mask & keep_nb(pick_dir);
				if (|cand) begin
					cur_mask_q <= cur_mask_q & keep_cur(pick_dir);
				end
				case (pick_dir)
					DIR_W: begin
						nx_q <= cx_q - CW'(1);
						ny_q <= cy_q;
					end
					DIR_E: begin
						nx_q <= cx_q + CW'(1);
						ny_q <= cy_q;
					end
					DIR_N: begin
						nx_q <= cx_q;
						ny_q <= cy_q - CW'(1);
					end
					DIR_S: begin
						nx_q <= cx_q;
						ny_q <= cy_q + CW'(1);
					end
					default: begin
						nx_q <= cx_q;
						ny_q <= cy_q;
					end
				endcase
			end
			S_OUT: begin
				if (out_free) begin
					rsp_q <= rsp_nxt;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/mdc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
